### rtl/qpmm_pkg.sv
// Shared types and constants of the quad plus-frame motor mixer.
package qpmm_pkg;

  localparam int unsigned N_LANES = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_HALF_ARM   = 3'd0,
    CFG_INV_QUAD_YAW   = 3'd1,
    CFG_DUTY_DIVISOR   = 3'd2,
    CFG_DUTY_THRESHOLD = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        thrust_mn;
    logic signed [15:0] pitch_moment;
    logic signed [15:0] roll_moment;
    logic signed [15:0] yaw_moment;
    logic [15:0]        battery_mv;
    logic               motors_unlocked;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_motor0;
    logic [15:0] duty_motor1;
    logic [15:0] duty_motor2;
    logic [15:0] duty_motor3;
    logic        drive_enable;
  } out_t;

  typedef struct packed {
    logic [23:0] inv_half_arm_q16;
    logic [23:0] inv_quad_yaw_ratio_q16;
    logic [15:0] duty_divisor;
    logic [11:0] duty_threshold;
  } cfg_t;

  // Per-request flags that ride along the pipeline next to the lanes.
  typedef struct packed {
    logic low_thrust;
    logic drive_enable;
  } side_t;

  localparam cfg_t CFG_RESET = '{
    inv_half_arm_q16:       24'd196608,
    inv_quad_yaw_ratio_q16: 24'd1024000,
    duty_divisor:           16'd208,
    duty_threshold:         12'd100
  };

  localparam logic [15:0] LOW_THRUST   = 16'd50;
  localparam int unsigned GAIN_BASE    = 303;
  localparam int unsigned GAIN_MIN     = 95;
  localparam int unsigned GAIN_MAX     = 125;
  localparam logic [6:0]  GAIN_UNKNOWN = 7'd110;
  // Quotients of battery_mv / 20 at which the gain clamps.
  localparam logic [11:0] GAIN_Q_FLOOR = 12'(GAIN_BASE - GAIN_MIN);
  localparam logic [11:0] GAIN_Q_CEIL  = 12'(GAIN_BASE - GAIN_MAX);
  // Reciprocals: floor(z/5) = (z*DIV5_RECIP)>>18 for z < 2^18,
  // floor(y/3) = (y*DIV3_RECIP)>>17 for y < 2^17.
  localparam logic [15:0] DIV5_RECIP   = 16'd52429;
  localparam logic [15:0] DIV3_RECIP   = 16'd43691;
  localparam logic [15:0] DUTY_BASE    = 16'd1000;

  localparam int unsigned QUOT_W         = 16;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

endpackage

### rtl/qpmm_cfg_regs.sv
// Configuration register bank of the motor mixer.
module qpmm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qpmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qpmm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output qpmm_pkg::cfg_t                      cfg
);

  qpmm_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        qpmm_pkg::CFG_INV_HALF_ARM:   cfg_nxt.inv_half_arm_q16 = cfg_data;
        qpmm_pkg::CFG_INV_QUAD_YAW:   cfg_nxt.inv_quad_yaw_ratio_q16 = cfg_data;
        qpmm_pkg::CFG_DUTY_DIVISOR:   cfg_nxt.duty_divisor = cfg_data[15:0];
        qpmm_pkg::CFG_DUTY_THRESHOLD: cfg_nxt.duty_threshold = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= qpmm_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/qpmm_mix.sv
// Front pipeline: moment scaling, rotor force mixing, battery gain and gain product.
module qpmm_mix (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  qpmm_pkg::in_t                               in_item,
  input  qpmm_pkg::cfg_t                              cfg,
  output logic                                        mix_valid,
  output qpmm_pkg::side_t                             mix_side,
  output logic [qpmm_pkg::N_LANES-1:0][31:0]          mix_num
);

  // Stage 1: products.
  logic                v1_r;
  qpmm_pkg::side_t     side1_r;
  logic [29:0]         q1_r;
  logic signed [39:0]  pt1_r, rt1_r, yt1_r;
  logic [11:0]         gq1_r;
  logic                mv_zero1_r;

  logic signed [40:0]  pt_full, rt_full, yt_full;
  logic [29:0]         gprod;

  always_comb begin
    pt_full = in_item.pitch_moment * $signed({1'b0, cfg.inv_half_arm_q16});
    rt_full = in_item.roll_moment * $signed({1'b0, cfg.inv_half_arm_q16});
    yt_full = in_item.yaw_moment * $signed({1'b0, cfg.inv_quad_yaw_ratio_q16});
    gprod   = 30'(in_item.battery_mv[15:2]) * 30'(qpmm_pkg::DIV5_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    q1_r                 <= {in_item.thrust_mn, 14'b0};
    pt1_r                <= pt_full[39:0];
    rt1_r                <= rt_full[39:0];
    yt1_r                <= yt_full[39:0];
    gq1_r                <= gprod[29:18];
    mv_zero1_r           <= (in_item.battery_mv == 16'd0);
    side1_r.low_thrust   <= (in_item.thrust_mn < qpmm_pkg::LOW_THRUST);
    side1_r.drive_enable <= in_item.motors_unlocked;
  end

  // Stage 2: forces and gain.
  logic                                    v2_r;
  qpmm_pkg::side_t                         side2_r;
  logic [qpmm_pkg::N_LANES-1:0][40:0]      mag2_r;
  logic [6:0]                              k2_r;

  logic signed [41:0] q_s, pt_s, rt_s, yt_s;
  logic signed [41:0] f [qpmm_pkg::N_LANES];
  logic [qpmm_pkg::N_LANES-1:0][40:0] mag_nxt;
  logic [11:0] k_wide;
  logic [6:0]  k_nxt;

  always_comb begin
    q_s  = $signed({12'b0, q1_r});
    pt_s = 42'(pt1_r);
    rt_s = 42'(rt1_r);
    yt_s = 42'(yt1_r);
    f[0] = q_s - pt_s + yt_s;
    f[1] = q_s - rt_s - yt_s;
    f[2] = q_s + pt_s + yt_s;
    f[3] = q_s + rt_s - yt_s;
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      // Forces at or below zero give no drive.
      mag_nxt[l] = f[l][41] ? 41'd0 : f[l][40:0];
    end
    k_wide = 12'(qpmm_pkg::GAIN_BASE) - gq1_r;
    if (mv_zero1_r) begin
      k_nxt = qpmm_pkg::GAIN_UNKNOWN;
    end else if (gq1_r >= qpmm_pkg::GAIN_Q_FLOOR) begin
      k_nxt = 7'(qpmm_pkg::GAIN_MIN);
    end else if (gq1_r <= qpmm_pkg::GAIN_Q_CEIL) begin
      k_nxt = 7'(qpmm_pkg::GAIN_MAX);
    end else begin
      k_nxt = k_wide[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    side2_r <= side1_r;
    mag2_r  <= mag_nxt;
    k2_r    <= k_nxt;
  end

  // Stage 3: gain product, scaled down by 2^16 ahead of the divider.
  logic                               v3_r;
  qpmm_pkg::side_t                    side3_r;
  logic [qpmm_pkg::N_LANES-1:0][31:0] num3_r;
  logic [47:0]                        prod [qpmm_pkg::N_LANES];

  always_comb begin
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      prod[l] = 48'(mag2_r[l]) * 48'(k2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      num3_r[l] <= prod[l][47:16];
    end
  end

  assign mix_valid = v3_r;
  assign mix_side  = side3_r;
  assign mix_num   = num3_r;

endmodule

### rtl/qpmm_div.sv
// Pipelined restoring divider by the duty divisor, four lanes, two quotient bits per stage.
module qpmm_div (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              div_in_valid,
  input  qpmm_pkg::side_t                                   div_in_side,
  input  logic [qpmm_pkg::N_LANES-1:0][31:0]                div_in_num,
  input  logic [15:0]                                       duty_divisor,
  output logic                                              div_valid,
  output qpmm_pkg::side_t                                   div_side,
  output logic [qpmm_pkg::N_LANES-1:0][qpmm_pkg::QUOT_W-1:0] div_raw
);

  localparam int unsigned NS = qpmm_pkg::DIV_STAGES;

  logic [15:0] mpe;
  assign mpe = (duty_divisor == 16'd0) ? 16'd1 : duty_divisor;

  logic                                 v_r    [0:NS];
  qpmm_pkg::side_t                      side_r [0:NS];
  logic [qpmm_pkg::N_LANES-1:0][15:0]   rem_r  [0:NS];
  logic [qpmm_pkg::N_LANES-1:0][15:0]   lo_r   [0:NS];
  logic [qpmm_pkg::N_LANES-1:0][15:0]   quot_r [0:NS];
  logic [qpmm_pkg::N_LANES-1:0]         sat_r  [0:NS];

  // One bit of long division: shift in the next dividend bit, subtract if it fits.
  function automatic logic [47:0] div_step(input logic [15:0] rem, input logic [15:0] lo,
                                           input logic [15:0] quot, input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] diff;
    logic        fit;
    t    = {rem, lo[15]};
    diff = t - {1'b0, d};
    fit  = (t >= {1'b0, d});
    return {fit ? diff[15:0] : t[15:0], lo[14:0], 1'b0, quot[14:0], fit};
  endfunction

  logic [47:0] step_nxt [1:NS][qpmm_pkg::N_LANES];

  always_comb begin
    for (int s = 1; s <= NS; s++) begin
      for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
        step_nxt[s][l] = {rem_r[s-1][l], lo_r[s-1][l], quot_r[s-1][l]};
        for (int b = 0; b < qpmm_pkg::BITS_PER_STAGE; b++) begin
          step_nxt[s][l] = div_step(step_nxt[s][l][47:32], step_nxt[s][l][31:16],
                                    step_nxt[s][l][15:0], mpe);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      v_r[0] <= div_in_valid;
      for (int s = 1; s <= NS; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  // Stage 0: a quotient beyond 16 bits saturates the raw duty.
  always_ff @(posedge clk) begin
    side_r[0] <= div_in_side;
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      rem_r[0][l]  <= div_in_num[l][31:16];
      lo_r[0][l]   <= div_in_num[l][15:0];
      quot_r[0][l] <= '0;
      sat_r[0][l]  <= (div_in_num[l][31:16] >= mpe);
    end
    for (int s = 1; s <= NS; s++) begin
      side_r[s] <= side_r[s-1];
      sat_r[s]  <= sat_r[s-1];
      for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
        rem_r[s][l]  <= step_nxt[s][l][47:32];
        lo_r[s][l]   <= step_nxt[s][l][31:16];
        quot_r[s][l] <= step_nxt[s][l][15:0];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      div_raw[l] = sat_r[NS][l] ? {qpmm_pkg::QUOT_W{1'b1}} : quot_r[NS][l];
    end
  end

  assign div_valid = v_r[NS];
  assign div_side  = side_r[NS];

`ifndef NO_ASSERTIONS
  // A finished lane that did not saturate leaves a remainder below the divisor.
  for (genvar g = 0; g < qpmm_pkg::N_LANES; g++) begin : g_rem_chk
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
      (v_r[NS] && !sat_r[NS][g]) |-> (rem_r[NS][g] < mpe))
      else $error("divider remainder not below divisor");
  end
`endif

endmodule

### rtl/qpmm_duty.sv
// Output stages: raw*5/12, threshold offset, low-thrust override and result register.
module qpmm_duty (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               duty_in_valid,
  input  qpmm_pkg::side_t                                    duty_in_side,
  input  logic [qpmm_pkg::N_LANES-1:0][qpmm_pkg::QUOT_W-1:0] duty_in_raw,
  input  logic [11:0]                                        duty_threshold,
  output logic                                               out_valid,
  output qpmm_pkg::out_t                                     out_result
);

  // Stage A: y = floor(raw*5/4), times the reciprocal of three.
  logic                               va_r;
  qpmm_pkg::side_t                    side_a_r;
  logic [qpmm_pkg::N_LANES-1:0][32:0] m_a_r;

  logic [18:0] x5 [qpmm_pkg::N_LANES];
  logic [32:0] m_nxt [qpmm_pkg::N_LANES];

  always_comb begin
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      x5[l]    = 19'(duty_in_raw[l]) + {1'b0, duty_in_raw[l], 2'b0};
      m_nxt[l] = 33'(x5[l][18:2]) * 33'(qpmm_pkg::DIV3_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= duty_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_a_r <= duty_in_side;
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      m_a_r[l] <= m_nxt[l];
    end
  end

  // Stage B: offsets, saturation and low-thrust override.
  logic           out_valid_r;
  qpmm_pkg::out_t out_r, out_nxt;
  logic [16:0]    sum [qpmm_pkg::N_LANES];
  logic [15:0]    duty [qpmm_pkg::N_LANES];

  always_comb begin
    for (int l = 0; l < qpmm_pkg::N_LANES; l++) begin
      sum[l] = 17'(m_a_r[l][32:17]) + 17'(duty_threshold) + 17'(qpmm_pkg::DUTY_BASE);
      if (side_a_r.low_thrust) begin
        duty[l] = qpmm_pkg::DUTY_BASE;
      end else begin
        duty[l] = sum[l][16] ? 16'hFFFF : sum[l][15:0];
      end
    end
    out_nxt.duty_motor0  = duty[0];
    out_nxt.duty_motor1  = duty[1];
    out_nxt.duty_motor2  = duty[2];
    out_nxt.duty_motor3  = duty[3];
    out_nxt.drive_enable = side_a_r.drive_enable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef NO_ASSERTIONS
  a_duty_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.duty_motor0 >= qpmm_pkg::DUTY_BASE) &&
                    (out_r.duty_motor1 >= qpmm_pkg::DUTY_BASE) &&
                    (out_r.duty_motor2 >= qpmm_pkg::DUTY_BASE) &&
                    (out_r.duty_motor3 >= qpmm_pkg::DUTY_BASE))
    else $error("duty below base value");

  a_low_thrust_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && side_a_r.low_thrust) |=>
      (out_r.duty_motor0 == qpmm_pkg::DUTY_BASE) &&
      (out_r.duty_motor1 == qpmm_pkg::DUTY_BASE) &&
      (out_r.duty_motor2 == qpmm_pkg::DUTY_BASE) &&
      (out_r.duty_motor3 == qpmm_pkg::DUTY_BASE))
    else $error("low thrust result not flat");

  a_enable_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_valid_r) |-> (out_r.drive_enable == $past(side_a_r.drive_enable)))
    else $error("drive enable does not follow its request");
`endif

endmodule

### rtl/quad_plus_motor_mixer_top.sv
// Top level of the quad plus-frame motor mixer.
//
//   channel  ports                                   transfer
//   request  start, busy, in_data                    start && !busy
//   result   out_valid, out_data                     out_valid, one cycle
//   config   cfg_we, cfg_index, cfg_data             cfg_we
//
// A request may be issued every cycle; busy stays low.
// Each result passes three mixing stages, nine divider stages (a saturation check,
// then the restoring divider by the duty divisor, two quotient bits per stage) and two
// output stages.
// Reset clears the valid bits of every stage and reloads the register defaults.
// The pipeline never stalls, since the receiver takes every result as it comes.
module quad_plus_motor_mixer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  qpmm_pkg::in_t                       in_data,
  output logic                                out_valid,
  output qpmm_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [qpmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qpmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  qpmm_pkg::cfg_t   cfg;
  logic             mix_valid;
  qpmm_pkg::side_t  mix_side;
  logic [qpmm_pkg::N_LANES-1:0][31:0] mix_num;
  logic             div_valid;
  qpmm_pkg::side_t  div_side;
  logic [qpmm_pkg::N_LANES-1:0][qpmm_pkg::QUOT_W-1:0] div_raw;

  assign busy = 1'b0;

  qpmm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qpmm_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_data),
    .cfg       (cfg),
    .mix_valid (mix_valid),
    .mix_side  (mix_side),
    .mix_num   (mix_num)
  );

  qpmm_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .div_in_valid (mix_valid),
    .div_in_side  (mix_side),
    .div_in_num   (mix_num),
    .duty_divisor (cfg.duty_divisor),
    .div_valid    (div_valid),
    .div_side     (div_side),
    .div_raw      (div_raw)
  );

  qpmm_duty u_duty (
    .clk            (clk),
    .rst_n          (rst_n),
    .duty_in_valid  (div_valid),
    .duty_in_side   (div_side),
    .duty_in_raw    (div_raw),
    .duty_threshold (cfg.duty_threshold),
    .out_valid      (out_valid),
    .out_result     (out_data)
  );

endmodule

### dv/quad_plus_motor_mixer_top_tb.sv
// Self-checking testbench for the quad plus-frame motor mixer: directed table, random requests.
module quad_plus_motor_mixer_top_tb;
  import qpmm_pkg::*;

  localparam int N_PHASES = 8;
  localparam int REQS_PER_PHASE = 160;
  localparam int MAX_GAP = 14;
  localparam int FLUSH_CYCLES = 20;
  localparam longint QUARTER_Q16 = 16384;
  localparam int MV_PER_GAIN_STEP = 20;
  localparam longint DUTY_NUM = 5;
  localparam longint DUTY_DEN = 12;
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = 3'd4;

  localparam out_t LOW_ON  = '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b1};
  localparam out_t LOW_OFF = '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b0};

  typedef struct packed {
    in_t  req;
    logic fixed;
    out_t want;
  } dir_row_t;

  localparam int N_DIRECTED = 18;
  // Requests are thrust, pitch, roll, yaw, battery, unlocked. Rows with fixed low carry
  // no typed result and go through the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{16'd0,     16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1}, 1'b1, LOW_ON},
    '{'{16'd49,    16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF,  1'b0}, 1'b1, LOW_OFF},
    '{'{16'd49,    16'h8000, 16'h8000, 16'h8000, 16'd1,     1'b1}, 1'b1, LOW_ON},
    '{'{16'd50,    16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1}, 1'b0, '0},
    '{'{16'hFFFF,  16'h0000, 16'h0000, 16'h0000, 16'd1,     1'b1}, 1'b0, '0},
    '{'{16'hFFFF,  16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF,  1'b1}, 1'b0, '0},
    '{'{16'hFFFF,  16'h8000, 16'h7FFF, 16'h8000, 16'd3559,  1'b0}, 1'b0, '0},
    '{'{16'd50,    16'h7FFF, 16'h0000, 16'h0000, 16'd3560,  1'b1}, 1'b0, '0},
    '{'{16'd50,    16'h0000, 16'h7FFF, 16'h8000, 16'd3579,  1'b1}, 1'b0, '0},
    '{'{16'd1000,  16'h0000, 16'h0000, 16'h8000, 16'd3580,  1'b1}, 1'b0, '0},
    '{'{16'd1000,  16'h0000, 16'h0000, 16'h7FFF, 16'd4159,  1'b1}, 1'b0, '0},
    '{'{16'd30000, 16'h0000, 16'h0000, 16'h0000, 16'd4160,  1'b1}, 1'b0, '0},
    '{'{16'd30000, 16'h0400, 16'hFC00, 16'h0100, 16'd3700,  1'b0}, 1'b0, '0},
    '{'{16'd12345, 16'h04D2, 16'hFB2E, 16'h004D, 16'd0,     1'b0}, 1'b0, '0},
    '{'{16'd65000, 16'hF000, 16'h1000, 16'hFF00, 16'd12000, 1'b1}, 1'b0, '0},
    '{'{16'd51,    16'h0001, 16'hFFFF, 16'h0001, 16'd3999,  1'b1}, 1'b0, '0},
    '{'{16'd40000, 16'h2AAA, 16'hD555, 16'h5555, 16'd5555,  1'b0}, 1'b0, '0},
    '{'{16'h8000,  16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000,  1'b1}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t mix_cfg = '{24'd196608, 24'd1024000, 16'd208, 12'd100};
  out_t duty_q[$];
  int mismatches = 0;

  quad_plus_motor_mixer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int battery_gain(logic [15:0] mv);
    int k;
    if (mv == 16'd0) return int'(GAIN_UNKNOWN);
    k = int'(GAIN_BASE) - int'(mv / MV_PER_GAIN_STEP);
    if (k < int'(GAIN_MIN)) k = int'(GAIN_MIN);
    if (k > int'(GAIN_MAX)) k = int'(GAIN_MAX);
    return k;
  endfunction

  function automatic logic [15:0] scale_duty(longint force_q16, int gain);
    longint unsigned divisor;
    longint unsigned raw;
    longint unsigned duty;
    divisor = (mix_cfg.duty_divisor == 16'd0) ? 64'd1 : 64'(mix_cfg.duty_divisor);
    raw = 0;
    if (force_q16 > 0) begin
      raw = (64'(force_q16) * 64'(gain)) / (divisor << 16);
      if (raw > 64'd65535) raw = 64'd65535;
    end
    duty = raw * DUTY_NUM / DUTY_DEN + 64'(mix_cfg.duty_threshold) + 64'(DUTY_BASE);
    if (duty > 64'd65535) duty = 64'd65535;
    return duty[15:0];
  endfunction

  function automatic out_t mix_duties(in_t req);
    longint quarter;
    longint pitch_t;
    longint roll_t;
    longint yaw_t;
    int gain;
    out_t res;
    res.drive_enable = req.motors_unlocked;
    if (req.thrust_mn < LOW_THRUST) begin
      res.duty_motor0 = DUTY_BASE;
      res.duty_motor1 = DUTY_BASE;
      res.duty_motor2 = DUTY_BASE;
      res.duty_motor3 = DUTY_BASE;
    end else begin
      quarter = longint'(req.thrust_mn) * QUARTER_Q16;
      pitch_t = longint'($signed(req.pitch_moment)) * longint'(mix_cfg.inv_half_arm_q16);
      roll_t  = longint'($signed(req.roll_moment)) * longint'(mix_cfg.inv_half_arm_q16);
      yaw_t   = longint'($signed(req.yaw_moment)) * longint'(mix_cfg.inv_quad_yaw_ratio_q16);
      gain = battery_gain(req.battery_mv);
      res.duty_motor0 = scale_duty(quarter - pitch_t + yaw_t, gain);
      res.duty_motor1 = scale_duty(quarter - roll_t - yaw_t, gain);
      res.duty_motor2 = scale_duty(quarter + pitch_t + yaw_t, gain);
      res.duty_motor3 = scale_duty(quarter + roll_t - yaw_t, gain);
    end
    return res;
  endfunction

  function automatic logic [15:0] random_moment();
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
      1, 2, 3: return 16'($urandom_range(0, 4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t random_req();
    in_t r;
    r.thrust_mn = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 60)) : 16'($urandom);
    r.pitch_moment = random_moment();
    r.roll_moment = random_moment();
    r.yaw_moment = random_moment();
    case ($urandom_range(0, 7))
      0: r.battery_mv = 16'd0;
      1, 2: r.battery_mv = 16'($urandom_range(3400, 4300));
      default: r.battery_mv = 16'($urandom);
    endcase
    r.motors_unlocked = 1'($urandom);
    return r;
  endfunction

  // Holds off for the drawn gap, then presents the request until the block takes it.
  task automatic issue(in_t req, int gap, logic fixed, out_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    duty_q.push_back(fixed ? want : mix_duties(req));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_INV_HALF_ARM: mix_cfg.inv_half_arm_q16 = data;
      CFG_INV_QUAD_YAW: mix_cfg.inv_quad_yaw_ratio_q16 = data;
      CFG_DUTY_DIVISOR: mix_cfg.duty_divisor = data[15:0];
      CFG_DUTY_THRESHOLD: mix_cfg.duty_threshold = data[11:0];
      default: ;
    endcase
  endtask

  task automatic configure(int phase);
    logic [23:0] half_arm;
    logic [23:0] yaw_ratio;
    logic [15:0] power;
    logic [11:0] threshold;
    case (phase)
      1: begin
        half_arm = 24'hFFFFFF;
        yaw_ratio = 24'hFFFFFF;
        power = 16'hFFFF;
        threshold = 12'hFFF;
      end
      2: begin
        half_arm = 24'd0;
        yaw_ratio = 24'd0;
        power = 16'd0;
        threshold = 12'd0;
      end
      3: begin
        half_arm = 24'($urandom_range(0, 65535));
        yaw_ratio = 24'($urandom_range(0, 65535));
        power = 16'd1;
        threshold = 12'($urandom);
      end
      default: begin
        half_arm = 24'($urandom) >> $urandom_range(0, 16);
        yaw_ratio = 24'($urandom) >> $urandom_range(0, 16);
        power = 16'($urandom) >> $urandom_range(0, 15);
        threshold = 12'($urandom);
      end
    endcase
    // Bits above the divisor and threshold widths are random and must be dropped by the block.
    write_reg(CFG_INV_HALF_ARM, half_arm);
    write_reg(CFG_INV_QUAD_YAW, yaw_ratio);
    write_reg(CFG_DUTY_DIVISOR, {8'($urandom), power});
    write_reg(CFG_DUTY_THRESHOLD, {12'($urandom), threshold});
    write_reg(FIRST_UNUSED_IDX + 3'($urandom_range(0, 3)), 24'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    logic bursty;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < N_DIRECTED; r++) begin
      issue(DIRECTED[r].req, $urandom_range(0, MAX_GAP), DIRECTED[r].fixed, DIRECTED[r].want);
    end
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        start <= 1'b0;
        wait (duty_q.size() == 0);
        repeat (2) @(posedge clk);
        configure(p);
      end
      // Every third phase sends back to back.
      bursty = (p % 3 == 1);
      for (int i = 0; i < REQS_PER_PHASE; i++) begin
        gap = bursty ? 0 : $urandom_range(0, MAX_GAP);
        issue(random_req(), gap, 1'b0, '0);
      end
    end
    start <= 1'b0;
    wait (duty_q.size() == 0);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_t want;
    logic [15:0] got_duty [4];
    logic [15:0] want_duty [4];
    if (rst_n && out_valid) begin
      if (duty_q.size() == 0) begin
        $display("%0t: result with no request waiting: %h", $time, out_data);
        mismatches++;
      end else begin
        want = duty_q.pop_front();
        got_duty = '{out_data.duty_motor0, out_data.duty_motor1,
                     out_data.duty_motor2, out_data.duty_motor3};
        want_duty = '{want.duty_motor0, want.duty_motor1,
                      want.duty_motor2, want.duty_motor3};
        for (int m = 0; m < 4; m++) begin
          if (got_duty[m] !== want_duty[m]) begin
            $display("%0t: duty_motor%0d expected %0d got %0d",
                     $time, m, want_duty[m], got_duty[m]);
            mismatches++;
          end
        end
        if (out_data.drive_enable !== want.drive_enable) begin
          $display("%0t: drive_enable expected %0b got %0b",
                   $time, want.drive_enable, out_data.drive_enable);
          mismatches++;
        end
      end
    end
  end

endmodule
